### rtl/egcd_pkg.sv
package egcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAX_STEPS  = 1000;
    localparam int FIELD_W    = 32;

    localparam int BIT_CNT_W  = $clog2(DATA_WIDTH);
    localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);

    typedef logic [DATA_WIDTH-1:0]     word_t;
    typedef logic signed [FIELD_W-1:0] field_t;

    typedef struct packed {
        field_t first_operand;
        field_t second_operand;
    } in_beat_t;

    typedef struct packed {
        field_t divisor_value;
        field_t coeff_first;
        field_t coeff_second;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic fix;
        logic mul_s;
        logic mul_t;
        logic update;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cur_zero;
    } dp_status_t;

    function automatic word_t magnitude(input word_t v);
        word_t m;
        m = v[DATA_WIDTH-1] ? (word_t'(0) - v) : v;
        return m;
    endfunction

endpackage

### rtl/egcd_ctrl.sv
module egcd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  egcd_pkg::dp_status_t  status,
    output egcd_pkg::dp_cmd_t     cmd
);

    localparam int BCW = egcd_pkg::BIT_CNT_W;
    localparam int SCW = egcd_pkg::STEP_CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_FIX    = 3'd3;
    localparam logic [2:0] ST_MUL_S  = 3'd4;
    localparam logic [2:0] ST_MUL_T  = 3'd5;
    localparam logic [2:0] ST_UPDATE = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0]     state_reg, state_next;
    logic [BCW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [SCW-1:0] step_cnt_reg, step_cnt_next;
    logic           m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        step_cnt_next = step_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.cur_zero || step_cnt_reg == SCW'(egcd_pkg::MAX_STEPS)) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_init = 1'b1;
                    bit_cnt_next = BCW'(egcd_pkg::DATA_WIDTH - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = ST_FIX;
                end else begin
                    bit_cnt_next = bit_cnt_reg - BCW'(1);
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                cmd.mul_s  = 1'b1;
                state_next = ST_MUL_T;
            end
            ST_MUL_T: begin
                cmd.mul_t  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update    = 1'b1;
                step_cnt_next = step_cnt_reg + SCW'(1);
                state_next    = ST_CHECK;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

### rtl/egcd_datapath.sv
module egcd_datapath (
    input  logic                  aclk,
    input  egcd_pkg::dp_cmd_t     cmd,
    input  egcd_pkg::in_beat_t    in_beat,
    output egcd_pkg::out_beat_t   out_beat,
    output egcd_pkg::dp_status_t  status
);

    localparam int DW = egcd_pkg::DATA_WIDTH;

    typedef egcd_pkg::word_t word_t;

    word_t rem_prev_reg, rem_prev_next;
    word_t rem_cur_reg, rem_cur_next;
    word_t s_prev_reg, s_prev_next;
    word_t s_cur_reg, s_cur_next;
    word_t t_prev_reg, t_prev_next;
    word_t t_cur_reg, t_cur_next;

    // restoring divider on magnitudes
    word_t quo_reg, quo_next;
    word_t part_reg, part_next;
    word_t m1_reg, m1_next;

    word_t q_reg, q_next;
    word_t r_reg, r_next;
    word_t prod_reg, prod_next;
    word_t s_new_reg, s_new_next;

    egcd_pkg::out_beat_t out_reg, out_next;

    logic [DW:0] shifted;
    logic [DW:0] trial;
    word_t       q_base;
    word_t       mul_op;
    logic        n0, n1;

    assign status.cur_zero = (rem_cur_reg == '0);
    assign out_beat        = out_reg;

    assign shifted = {part_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, m1_reg};
    assign n0      = rem_prev_reg[DW-1];
    assign n1      = rem_cur_reg[DW-1];
    assign q_base  = (n0 ^ n1) ? (word_t'(0) - quo_reg) : quo_reg;
    assign mul_op  = cmd.mul_t ? t_cur_reg : s_cur_reg;

    always_comb begin
        rem_prev_next = rem_prev_reg;
        rem_cur_next  = rem_cur_reg;
        s_prev_next   = s_prev_reg;
        s_cur_next    = s_cur_reg;
        t_prev_next   = t_prev_reg;
        t_cur_next    = t_cur_reg;
        quo_next      = quo_reg;
        part_next     = part_reg;
        m1_next       = m1_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        prod_next     = prod_reg;
        s_new_next    = s_new_reg;
        out_next      = out_reg;

        if (cmd.load) begin
            rem_prev_next = word_t'(in_beat.first_operand);
            rem_cur_next  = word_t'(in_beat.second_operand);
            s_prev_next   = word_t'(1);
            s_cur_next    = '0;
            t_prev_next   = '0;
            t_cur_next    = word_t'(1);
        end

        if (cmd.div_init) begin
            quo_next  = egcd_pkg::magnitude(rem_prev_reg);
            part_next = '0;
            m1_next   = egcd_pkg::magnitude(rem_cur_reg);
        end

        if (cmd.div_step) begin
            if (!trial[DW]) begin
                part_next = trial[DW-1:0];
                quo_next  = {quo_reg[DW-2:0], 1'b1};
            end else begin
                part_next = shifted[DW-1:0];
                quo_next  = {quo_reg[DW-2:0], 1'b0};
            end
        end

        // negative remainder moves up by |divisor|, quotient steps opposite to the divisor sign
        if (cmd.fix) begin
            if (n0 && part_reg != '0) begin
                r_next = m1_reg - part_reg;
                q_next = n1 ? (q_base + word_t'(1)) : (q_base - word_t'(1));
            end else begin
                r_next = part_reg;
                q_next = q_base;
            end
        end

        if (cmd.mul_s || cmd.mul_t) begin
            prod_next = word_t'(q_reg * mul_op);
        end

        if (cmd.mul_t) begin
            s_new_next = s_prev_reg - prod_reg;
        end

        if (cmd.update) begin
            rem_prev_next = rem_cur_reg;
            rem_cur_next  = r_reg;
            s_prev_next   = s_cur_reg;
            s_cur_next    = s_new_reg;
            t_prev_next   = t_cur_reg;
            t_cur_next    = t_prev_reg - prod_reg;
        end

        if (cmd.out_load) begin
            out_next.divisor_value = egcd_pkg::field_t'($signed(rem_prev_reg));
            out_next.coeff_first   = egcd_pkg::field_t'($signed(s_prev_reg));
            out_next.coeff_second  = egcd_pkg::field_t'($signed(t_prev_reg));
        end
    end

    always_ff @(posedge aclk) begin
        rem_prev_reg <= rem_prev_next;
        rem_cur_reg  <= rem_cur_next;
        s_prev_reg   <= s_prev_next;
        s_cur_reg    <= s_cur_next;
        t_prev_reg   <= t_prev_next;
        t_cur_reg    <= t_cur_next;
        quo_reg      <= quo_next;
        part_reg     <= part_next;
        m1_reg       <= m1_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        prod_reg     <= prod_next;
        s_new_reg    <= s_new_next;
        out_reg      <= out_next;
    end

endmodule

### rtl/extended_gcd_engine.sv
// channel   dir  handshake          beat
// s_        in   s_valid/s_ready    in_beat_t  {first_operand, second_operand}
// m_        out  m_valid/m_ready    out_beat_t {divisor_value, coeff_first, coeff_second}
//
// an item is loaded, runs its steps and ends in the finish state (steps: 0 when the second operand is zero, else the
// euclid step count, at most MAX_STEPS); a step is the check, the divider pass over all quotient bits, fix,
// two passes through the shared multiplier and the register update
// aresetn is synchronous; no clearing pass is needed after reset
// a new item is taken while the previous result waits on m_ready; a finished item holds
// in its last state until the output register is free
module extended_gcd_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  egcd_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output egcd_pkg::out_beat_t  m_data
);

    egcd_pkg::dp_cmd_t    cmd;
    egcd_pkg::dp_status_t status;

    egcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    egcd_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_beat  (s_data),
        .out_beat (m_data),
        .status   (status)
    );

endmodule

### rtl/egcd_checker.sv
module egcd_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input egcd_pkg::in_beat_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input egcd_pkg::out_beat_t  m_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // busy right after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accept");

    // a new result appears only as the engine returns to idle
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready && !$past(s_ready))
        else $error("result raised outside finish");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear control state");

endmodule

bind extended_gcd_engine egcd_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
